// File: sv/sts_pkg.sv
package sts_pkg;

    localparam int KEY_W   = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int POS_W   = 4;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [COUNT_W-1:0]      count_t;

endpackage

// File: sv/sorted_table_binary_search.sv
// Sorted-table binary search.
// The slave channel takes words of two kinds, selected by s_axis_tuser: a write
// word stores key_value at entry_index, and a search word looks for key_value
// among the first entry_count entries, which must be stored in ascending order.
// A write gives no result. A search gives one word on the master channel with
// the found flag in m_axis_tuser and the matching position in m_axis_tdata.
// The entry count is set through cfg_wr_en and cfg_wr_data; the user must do so
// only while idle, as the block itself does not enforce it. A search starts
// when its word is accepted. Each probe reads the key memory through its single
// read port in ST_PROBE and compares in ST_CMP; the search finishes when a key
// matches or the range left to probe is empty.
// Only one search runs at a time; the slave channel is ready again once the
// result sits in the output register, even while the receiver has not taken it.
// When the receiver stalls, a finished search waits until the output register
// is free. Reset clears the entry count and empties the output register; the
// key memory keeps its contents and must be written before it is searched.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sts_pkg::COUNT_W-1:0]     cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // entry_index [3:0], key_value [35:4], zero [39:36]
    input  logic [sts_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // operation [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // position [3:0], zero [7:4]
    output logic [sts_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // found [0]
    output logic                            m_axis_tuser
);

    localparam int AW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MAX_C_INT = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;
    localparam int MAX_W_INT = (TABLE_DEPTH < 16) ? TABLE_DEPTH : 16;
    localparam logic [sts_pkg::COUNT_W-1:0] MAX_COUNT = sts_pkg::COUNT_W'(MAX_C_INT);
    localparam logic [sts_pkg::COUNT_W-1:0] MAX_WRITE = sts_pkg::COUNT_W'(MAX_W_INT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP
    } state_t;

    state_t                        state_reg;
    sts_pkg::count_t               entry_count_reg;
    sts_pkg::count_t               low_reg;
    sts_pkg::count_t               end_reg;
    sts_pkg::count_t               mid_reg;
    sts_pkg::key_t                 target_reg;
    sts_pkg::key_t                 rd_data_reg;
    logic                          m_valid_reg;
    logic                          found_reg;
    logic [sts_pkg::POS_W-1:0]     position_reg;

    logic [sts_pkg::KEY_W-1:0]     key_mem [TABLE_DEPTH];

    logic                          in_fire;
    logic                          out_free;
    logic                          result_load;
    logic [sts_pkg::INDEX_W-1:0]   in_index;
    sts_pkg::key_t                 in_key;
    sts_pkg::count_t               count_sat;
    sts_pkg::count_t               span;
    sts_pkg::count_t               mid_next;
    logic                          wr_en;
    logic                          rd_en;

    assign in_index  = s_axis_tdata[sts_pkg::INDEX_W-1:0];
    assign in_key    = s_axis_tdata[sts_pkg::INDEX_W +: sts_pkg::KEY_W];
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign count_sat = (entry_count_reg > MAX_COUNT) ? MAX_COUNT : entry_count_reg;
    assign span      = end_reg - low_reg - sts_pkg::COUNT_W'(1);
    assign mid_next  = low_reg + (span >> 1);
    assign wr_en     = in_fire && (s_axis_tuser == sts_pkg::OP_WRITE)
                       && ({1'b0, in_index} < MAX_WRITE);
    assign rd_en     = (state_reg == ST_PROBE) && (low_reg < end_reg);
    assign result_load = out_free
                         && (((state_reg == ST_PROBE) && !(low_reg < end_reg))
                             || ((state_reg == ST_CMP) && (rd_data_reg == target_reg)));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = found_reg;
    assign m_axis_tdata  = {{(sts_pkg::M_TDATA_W - sts_pkg::POS_W){1'b0}}, position_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[AW'(in_index)] <= in_key;
        end
        if (rd_en) begin
            rd_data_reg <= key_mem[AW'(mid_next)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                entry_count_reg <= cfg_wr_data;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire && (s_axis_tuser == sts_pkg::OP_SEARCH)) begin
                        target_reg <= in_key;
                        low_reg    <= '0;
                        end_reg    <= count_sat;
                        state_reg  <= ST_PROBE;
                    end
                end
                ST_PROBE: begin
                    if (low_reg < end_reg) begin
                        mid_reg   <= mid_next;
                        state_reg <= ST_CMP;
                    end else if (out_free) begin
                        found_reg    <= 1'b0;
                        position_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_CMP: begin
                    if (rd_data_reg == target_reg) begin
                        if (out_free) begin
                            found_reg    <= 1'b1;
                            position_reg <= mid_reg[sts_pkg::POS_W-1:0];
                            state_reg    <= ST_IDLE;
                        end
                    end else if (rd_data_reg < target_reg) begin
                        low_reg   <= mid_reg + sts_pkg::COUNT_W'(1);
                        state_reg <= ST_PROBE;
                    end else begin
                        end_reg   <= mid_reg;
                        state_reg <= ST_PROBE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: test/sorted_table_binary_search_tb.sv
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;

    localparam int TABLE_DEPTH   = 16;
    localparam int BLOCK_LATENCY = 16;
    localparam int PHASE_WORDS   = 225;
    localparam int PHASE_COUNT   = 8;
    localparam int IDLE_PCT      = 54;
    localparam int BOTH_IDLE_PCT = 32;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic                        op;
        logic [sts_pkg::INDEX_W-1:0] index;
        sts_pkg::key_t               key;
    } table_word_t;

    typedef struct packed {
        logic                      found;
        logic [sts_pkg::POS_W-1:0] position;
    } search_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [sts_pkg::COUNT_W-1:0]   cfg_wr_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [sts_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                          s_axis_tuser = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [sts_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tuser;

    table_word_t     pending_words[$];
    search_result_t  pending_results[$];
    sts_pkg::key_t   key_mirror[TABLE_DEPTH];
    sts_pkg::key_t   planned_keys[TABLE_DEPTH];
    sts_pkg::count_t count_mirror = '0;
    idle_mode_t      idle_mode = IDLE_NONE;
    int              items_driven = 0;
    int              items_accepted = 0;
    int              mismatch_count = 0;

    sorted_table_binary_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int idle_pct(input bit sender_side);
        case (idle_mode)
            IDLE_SENDER:   return sender_side ? IDLE_PCT : 0;
            IDLE_RECEIVER: return sender_side ? 0 : IDLE_PCT;
            IDLE_BOTH:     return BOTH_IDLE_PCT;
            default:       return 0;
        endcase
    endfunction

    function automatic search_result_t search_mirror(input sts_pkg::key_t target);
        search_result_t res;
        int lo;
        int hi;
        int mid;
        res = '0;
        lo = 0;
        hi = (int'(count_mirror) > TABLE_DEPTH ? TABLE_DEPTH : int'(count_mirror)) - 1;
        while (lo <= hi && !res.found) begin
            mid = lo + (hi - lo) / 2;
            if (key_mirror[mid] == target) begin
                res.found = 1'b1;
                res.position = mid[sts_pkg::POS_W-1:0];
            end else if (key_mirror[mid] < target) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return res;
    endfunction

    task automatic queue_word(input logic op, input int index, input sts_pkg::key_t key);
        table_word_t w;
        w.op = op;
        w.index = index[sts_pkg::INDEX_W-1:0];
        w.key = key;
        if (op == sts_pkg::OP_WRITE) begin
            planned_keys[w.index] = key;
        end
        pending_words.push_back(w);
    endtask

    // Loads the whole table with ascending keys, sometimes dense enough to repeat.
    task automatic queue_sorted_table();
        longint v;
        longint step_cap;
        case ($urandom_range(0, 2))
            0: step_cap = 3;
            1: step_cap = 4096;
            default: step_cap = 64'd1 << 28;
        endcase
        v = roll(12) ? -64'sd2147483648 : longint'($signed($urandom));
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (v > 64'sd2147483647) begin
                v = 64'sd2147483647;
            end
            queue_word(sts_pkg::OP_WRITE, i, sts_pkg::key_t'(v));
            v = v + longint'($urandom_range(0, 32'(step_cap)));
        end
    endtask

    task automatic drain_block();
        while (pending_words.size() != 0 || items_accepted != items_driven
               || pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (BLOCK_LATENCY) @(posedge aclk);
    endtask

    task automatic write_count(input sts_pkg::count_t value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(negedge aclk) begin : word_driver
        table_word_t w;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || items_accepted == items_driven) begin
            if (pending_words.size() != 0 && !roll(idle_pct(1'b1))) begin
                w = pending_words.pop_front();
                s_axis_tdata <= {{(sts_pkg::S_TDATA_W - sts_pkg::KEY_W
                                   - sts_pkg::INDEX_W){1'b0}}, w.key, w.index};
                s_axis_tuser <= w.op;
                s_axis_tvalid <= 1'b1;
                items_driven++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_axis_tready <= !roll(idle_pct(1'b0));
    end

    always @(posedge aclk) begin : word_monitor
        search_result_t expected;
        if (aresetn) begin
            if (cfg_wr_en) begin
                count_mirror = cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                items_accepted <= items_accepted + 1;
                if (s_axis_tuser == sts_pkg::OP_WRITE) begin
                    key_mirror[s_axis_tdata[sts_pkg::INDEX_W-1:0]] =
                        s_axis_tdata[sts_pkg::INDEX_W +: sts_pkg::KEY_W];
                end else begin
                    pending_results.push_back(
                        search_mirror(s_axis_tdata[sts_pkg::INDEX_W +: sts_pkg::KEY_W]));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result word: found %0d position %0d",
                           m_axis_tuser, m_axis_tdata[sts_pkg::POS_W-1:0]);
                    mismatch_count++;
                end else begin
                    expected = pending_results.pop_front();
                    if (m_axis_tuser !== expected.found) begin
                        $error("found: expected %0d, actual %0d", expected.found, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[sts_pkg::POS_W-1:0] !== expected.position) begin
                        $error("position: expected %0d, actual %0d",
                               expected.position, m_axis_tdata[sts_pkg::POS_W-1:0]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        sts_pkg::count_t phase_counts[PHASE_COUNT];
        int queued;
        int pick;
        sts_pkg::key_t probe_key;

        phase_counts = '{5'd31, 5'd0, 5'd1, 5'd16, 5'd17,
                         sts_pkg::count_t'($urandom_range(2, 15)), 5'd15,
                         sts_pkg::count_t'($urandom_range(18, 30))};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The entry count is still zero here, so this search sees an empty table.
        queue_word(sts_pkg::OP_SEARCH, 0, 32'sd0);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            queue_word(sts_pkg::OP_WRITE, i, sts_pkg::key_t'((i - 8) * 268435456));
        end
        queue_word(sts_pkg::OP_WRITE, 9, 32'sd0);
        queue_word(sts_pkg::OP_WRITE, 15, 32'sh7fffffff);
        drain_block();
        write_count(5'd16);
        queue_word(sts_pkg::OP_SEARCH, 15, -32'sh80000000);
        queue_word(sts_pkg::OP_SEARCH, 0, 32'sh7fffffff);
        queue_word(sts_pkg::OP_SEARCH, 0, 32'sd0);
        queue_word(sts_pkg::OP_SEARCH, 0, sts_pkg::key_t'(3 * 268435456));
        queue_word(sts_pkg::OP_SEARCH, 0, 32'sd5);
        queue_word(sts_pkg::OP_SEARCH, 0, -32'sd1);
        drain_block();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_count(phase_counts[p]);
            idle_mode = idle_mode_t'(p % 4);
            queued = 0;
            while (queued < PHASE_WORDS) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    queue_sorted_table();
                    queued += TABLE_DEPTH;
                end else begin
                    if (pick < 80) begin
                        probe_key = planned_keys[$urandom_range(0, TABLE_DEPTH - 1)];
                        queue_word(sts_pkg::OP_SEARCH, $urandom_range(0, 15), probe_key);
                    end else if (pick < 86) begin
                        probe_key = planned_keys[$urandom_range(0, TABLE_DEPTH - 1)];
                        probe_key = roll(50) ? probe_key + 1 : probe_key - 1;
                        queue_word(sts_pkg::OP_SEARCH, $urandom_range(0, 15), probe_key);
                    end else if (pick < 92) begin
                        queue_word(sts_pkg::OP_SEARCH, $urandom_range(0, 15),
                                   sts_pkg::key_t'($urandom));
                    end else begin
                        queue_word(sts_pkg::OP_WRITE, $urandom_range(0, 15),
                                   sts_pkg::key_t'($urandom));
                    end
                    queued++;
                end
            end
            drain_block();
        end

        idle_mode = IDLE_NONE;
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
sv/sts_pkg.sv
sv/sorted_table_binary_search.sv
test/sorted_table_binary_search_tb.sv
